// ----- hw/rtl/pida_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and codes for the positional insert/delete array core.
// ----------------------------------------------------------------------------
package pida_pkg;

    localparam int CountW = 7;
    localparam int DataW  = 32;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_DELETE  = 2'd1;
    localparam logic [1:0] MODE_DISPLAY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [6:0]              position;
        logic signed [DataW-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic [CountW-1:0]       count;
        logic signed [DataW-1:0] value_out;
        logic                    last;
    } t_out_item;

    typedef enum logic [1:0] {
        DP_NONE,
        DP_INSERT,
        DP_DELETE,
        DP_ROTATE
    } t_dp_op;

    // controller to datapath
    typedef struct packed {
        t_dp_op     op;
        logic       load;
        logic [1:0] status;
        logic       last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CountW-1:0] count;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/pida_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pida_dp
// Datapath: a chain of entry cells with the live count and the result
// register. Every cell picks its next value from itself, a neighbor, the
// head cell or the input value, so each command moves all cells at once.
// ----------------------------------------------------------------------------
module pida_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pida_pkg::t_in_item  i_in_item,
    input  wire pida_pkg::t_dp_cmd   i_cmd,
    output pida_pkg::t_dp_stat       o_stat,
    output pida_pkg::t_out_item      o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [pida_pkg::DataW-1:0] r_cell [DEPTH];
    logic [pida_pkg::DataW-1:0] n_cell [DEPTH];
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    pida_pkg::t_out_item        r_out;
    logic [pida_pkg::CountW-1:0] w_cnt7;
    logic [6:0]                 w_pos;

    assign w_cnt7 = pida_pkg::CountW'(r_count);
    assign w_pos  = i_in_item.position;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [pida_pkg::DataW-1:0] w_below;
            logic [pida_pkg::DataW-1:0] w_above;
            logic [6:0]                 w_idx;

            assign w_idx = 7'(gi);

            if (gi > 0) begin : g_below
                assign w_below = r_cell[gi-1];
            end else begin : g_below_none
                assign w_below = '0;
            end

            if (gi < DEPTH - 1) begin : g_above
                assign w_above = r_cell[gi+1];
            end else begin : g_above_none
                assign w_above = r_cell[0];
            end

            always_comb begin
                n_cell[gi] = r_cell[gi];
                case (i_cmd.op)
                    pida_pkg::DP_INSERT: begin
                        if (w_idx == w_pos) begin
                            n_cell[gi] = i_in_item.value_in;
                        end else if (w_idx > w_pos && w_idx <= w_cnt7) begin
                            n_cell[gi] = w_below;
                        end
                    end
                    pida_pkg::DP_DELETE: begin
                        if (w_idx >= w_pos && (w_idx + 7'd1) < w_cnt7) begin
                            n_cell[gi] = w_above;
                        end
                    end
                    pida_pkg::DP_ROTATE: begin
                        // live entries rotate down, head wraps to the tail
                        if ((w_idx + 7'd1) < w_cnt7) begin
                            n_cell[gi] = w_above;
                        end else if ((w_idx + 7'd1) == w_cnt7) begin
                            n_cell[gi] = r_cell[0];
                        end
                    end
                    default: begin
                        n_cell[gi] = r_cell[gi];
                    end
                endcase
            end

            always_ff @(posedge i_clk) begin
                r_cell[gi] <= n_cell[gi];
            end
        end
    endgenerate

    always_comb begin
        case (i_cmd.op)
            pida_pkg::DP_INSERT: n_count = r_count + CW'(1);
            pida_pkg::DP_DELETE: n_count = r_count - CW'(1);
            default:             n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.status    <= i_cmd.status;
            r_out.count     <= pida_pkg::CountW'(n_count);
            r_out.value_out <= (i_cmd.op == pida_pkg::DP_ROTATE) ? r_cell[0] : '0;
            r_out.last      <= i_cmd.last;
        end
    end

    assign o_stat.count = w_cnt7;
    assign o_out_item   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt7 <= pida_pkg::CountW'(DEPTH))
        else $error("live count above depth");

endmodule

`default_nettype wire

// ----- hw/rtl/pida_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pida_ctrl
// Controller: checks each item against the live count, issues datapath
// commands and sequences the display stream one entry per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pida_ctrl #(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pida_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire pida_pkg::t_dp_stat i_stat,
    output pida_pkg::t_dp_cmd       o_cmd
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_out_free;
    logic              w_accept;
    logic [6:0]        w_cnt;
    pida_pkg::t_dp_cmd w_cmd;

    assign w_cnt      = i_stat.count;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        w_cmd   = '{op: pida_pkg::DP_NONE, load: 1'b0,
                    status: pida_pkg::ST_OK, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.mode)
                        pida_pkg::MODE_INSERT: begin
                            w_cmd.load = 1'b1;
                            if (w_cnt >= 7'(DEPTH)) begin
                                w_cmd.status = pida_pkg::ST_FULL;
                            end else if (i_in_item.position > w_cnt) begin
                                w_cmd.status = pida_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op = pida_pkg::DP_INSERT;
                            end
                        end
                        pida_pkg::MODE_DELETE: begin
                            w_cmd.load = 1'b1;
                            if (w_cnt == 7'd0) begin
                                w_cmd.status = pida_pkg::ST_EMPTY;
                            end else if (i_in_item.position >= w_cnt) begin
                                w_cmd.status = pida_pkg::ST_BADPOS;
                            end else begin
                                w_cmd.op = pida_pkg::DP_DELETE;
                            end
                        end
                        pida_pkg::MODE_DISPLAY: begin
                            if (w_cnt == 7'd0) begin
                                w_cmd.load   = 1'b1;
                                w_cmd.status = pida_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DISP;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                            // unused mode: item dropped
                            w_cmd.load = 1'b0;
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (w_out_free) begin
                    w_cmd.op   = pida_pkg::DP_ROTATE;
                    w_cmd.load = 1'b1;
                    w_cmd.last = ((7'(r_idx) + 7'd1) == w_cnt);
                    if (w_cmd.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_cmd.load)
        else $error("result register overwritten while stalled");

    a_disp_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> (7'(r_idx) < w_cnt))
        else $error("display index past live count");

    a_disp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP && n_state == S_IDLE) |-> (w_cmd.load && w_cmd.last))
        else $error("display ended without flagging the last item");

endmodule

`default_nettype wire

// ----- hw/rtl/positional_insert_delete_array_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_delete_array_core
// Packed array of signed 32-bit entries with positional insert, delete and
// in-order display.
// ----------------------------------------------------------------------------
// Insert and delete give one item each; the entries sit in a chain of
// cells that all shift together, so the size of the move costs nothing.
// Display of a non-empty array streams count items, one per cycle while
// the output is not stalled, by rotating the live cells through the head
// cell; no new item is taken until the last one is out. Errors and an
// empty display give one item and change nothing. A single result
// register separates the two sides, so an item is accepted while a result
// waits, as long as that result is being taken.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_core #(
    parameter int DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire pida_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output pida_pkg::t_out_item      o_out_item
);

    pida_pkg::t_dp_cmd  w_cmd;
    pida_pkg::t_dp_stat w_stat;

    pida_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pida_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/delete array core. A
// scoreboard model of the array predicts every result item. Directed items
// cover the edge cases, then random runs of inserts, deletes and displays
// fill, churn and drain the array while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH = 64;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 310;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        pida_pkg::t_in_item item;
        bit                 hold_for_empty;
    } t_stim_entry;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_kind;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    pida_pkg::t_in_item  in_item = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    pida_pkg::t_out_item out_item;

    // scoreboard copy of the array
    logic signed [pida_pkg::DataW-1:0] array_entries [DEPTH];
    int                                array_count = 0;

    t_stim_entry         item_backlog [$];
    pida_pkg::t_out_item predicted_results [$];
    int                  mismatch_count = 0;

    // stimulus planning
    int planned_count = 0;
    int planned_items = 0;
    bit hold_next = 1'b0;

    // sender pacing
    int gap_left = 0;
    int burst_left = 8;

    // receiver pacing
    t_stall_kind stall_kind = STALL_NONE;
    int          stall_phase_left = 40;
    int          stall_tick = 0;

    pida_pkg::t_out_item got;
    pida_pkg::t_out_item want;

    always #4 i_clk = ~i_clk;

    positional_insert_delete_array_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    task automatic apply_array_op(input pida_pkg::t_in_item it);
        pida_pkg::t_out_item r;
        int                  i;
        r = '0;
        r.last = 1'b1;
        case (it.mode)
            pida_pkg::MODE_INSERT: begin
                if (array_count >= DEPTH) begin
                    r.status = pida_pkg::ST_FULL;
                end else if (it.position > array_count) begin
                    r.status = pida_pkg::ST_BADPOS;
                end else begin
                    for (i = array_count; i > it.position; i--)
                        array_entries[i] = array_entries[i-1];
                    array_entries[it.position] = it.value_in;
                    array_count++;
                    r.status = pida_pkg::ST_OK;
                end
                r.count = pida_pkg::CountW'(array_count);
                predicted_results.push_back(r);
            end
            pida_pkg::MODE_DELETE: begin
                if (array_count == 0) begin
                    r.status = pida_pkg::ST_EMPTY;
                end else if (it.position >= array_count) begin
                    r.status = pida_pkg::ST_BADPOS;
                end else begin
                    for (i = it.position; i + 1 < array_count; i++)
                        array_entries[i] = array_entries[i+1];
                    array_count--;
                    r.status = pida_pkg::ST_OK;
                end
                r.count = pida_pkg::CountW'(array_count);
                predicted_results.push_back(r);
            end
            pida_pkg::MODE_DISPLAY: begin
                if (array_count == 0) begin
                    r.status = pida_pkg::ST_EMPTY;
                    predicted_results.push_back(r);
                end else begin
                    for (i = 0; i < array_count; i++) begin
                        r.status = pida_pkg::ST_OK;
                        r.count = pida_pkg::CountW'(array_count);
                        r.value_out = array_entries[i];
                        r.last = (i + 1 == array_count);
                        predicted_results.push_back(r);
                    end
                end
            end
            default: begin
                // unused mode, no item out
            end
        endcase
    endtask

    task automatic add_item(input logic [1:0] mode, input int pos,
                            input logic signed [pida_pkg::DataW-1:0] val);
        t_stim_entry e;
        e.item.mode = mode;
        e.item.position = 7'(pos);
        e.item.value_in = val;
        e.hold_for_empty = hold_next;
        hold_next = 1'b0;
        item_backlog.push_back(e);
        if (mode != MODE_UNUSED)
            planned_items++;
        if (mode == pida_pkg::MODE_INSERT && planned_count < DEPTH && pos <= planned_count)
            planned_count++;
        else if (mode == pida_pkg::MODE_DELETE && planned_count > 0 && pos < planned_count)
            planned_count--;
    endtask

    function automatic logic signed [pida_pkg::DataW-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sh1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_mixed_op();
        int r;
        int del_pos;
        r = $urandom_range(0, 99);
        del_pos = (planned_count > 0) ? $urandom_range(0, planned_count - 1)
                                      : $urandom_range(0, 127);
        if (r < 45)
            add_item(pida_pkg::MODE_INSERT, $urandom_range(0, planned_count), pick_value());
        else if (r < 70)
            add_item(pida_pkg::MODE_DELETE, del_pos, $urandom);
        else if (r < 80)
            add_item(pida_pkg::MODE_DISPLAY, $urandom_range(0, 127), $urandom);
        else if (r < 87)
            add_item(pida_pkg::MODE_INSERT, $urandom_range(planned_count + 1, 127),
                     pick_value());
        else if (r < 94)
            add_item(pida_pkg::MODE_DELETE, $urandom_range(planned_count, 127), $urandom);
        else if (r < 97)
            add_item(MODE_UNUSED, $urandom_range(0, 127), $urandom);
        else
            add_item(pida_pkg::MODE_INSERT, $urandom_range(0, 1) ? planned_count : 0,
                     pick_value());
    endtask

    // sender: bursts of items with random gaps in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_array_op(in_item);
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (item_backlog.size() != 0 &&
                             !(item_backlog[0].hold_for_empty &&
                               predicted_results.size() != 0)) begin
                    in_item <= item_backlog[0].item;
                    in_valid <= 1'b1;
                    void'(item_backlog.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: picks a new random stall pattern when each phase ends, checks each item
    always @(posedge i_clk) begin
        stall_phase_left--;
        if (stall_phase_left <= 0) begin
            stall_kind = t_stall_kind'($urandom_range(0, 3));
            stall_phase_left = $urandom_range(20, 80);
        end
        stall_tick++;
        case (stall_kind)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= $urandom_range(0, 1);
            STALL_PERIODIC: out_stall <= (stall_tick % 3 != 0);
            default:        out_stall <= 1'b0;
        endcase

        if (i_rst_n && out_valid && !out_stall) begin
            got = out_item;
            if (predicted_results.size() == 0) begin
                $display("%0t: unexpected item, expected none actual status %0d count %0d",
                         $time, got.status, got.count);
                $display("%0t: unexpected item, actual value %0d last %0d",
                         $time, got.value_out, got.last);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: count mismatch, expected %0d actual %0d",
                             $time, want.count, got.count);
                    mismatch_count++;
                end
                if (got.value_out !== want.value_out) begin
                    $display("%0t: value_out mismatch, expected %0d actual %0d",
                             $time, want.value_out, got.value_out);
                    mismatch_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0d actual %0d",
                             $time, want.last, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int seq_no;
        int floor_count;
        bit room_for_long;

        // directed: empty, bad positions, extremes, first and last entry
        add_item(pida_pkg::MODE_DISPLAY, 0, 0);
        add_item(pida_pkg::MODE_DELETE, 0, 0);
        add_item(pida_pkg::MODE_INSERT, 1, 32'sh1234_5678);
        add_item(pida_pkg::MODE_INSERT, 127, -32'sh1);
        add_item(pida_pkg::MODE_INSERT, 0, 32'sh7fff_ffff);
        add_item(pida_pkg::MODE_INSERT, 0, 32'sh8000_0000);
        add_item(pida_pkg::MODE_INSERT, 2, -32'sh1);
        add_item(pida_pkg::MODE_INSERT, 1, 32'sh0);
        add_item(pida_pkg::MODE_DISPLAY, 127, -32'sh1);
        add_item(pida_pkg::MODE_DELETE, 4, 0);
        add_item(pida_pkg::MODE_DELETE, 127, -32'sh1);
        add_item(MODE_UNUSED, 127, -32'sh1);
        add_item(pida_pkg::MODE_INSERT, 3, 32'sh5555_aaaa);
        add_item(pida_pkg::MODE_DISPLAY, 0, 0);
        add_item(pida_pkg::MODE_DELETE, 4, 0);
        add_item(pida_pkg::MODE_DELETE, 0, 0);
        add_item(pida_pkg::MODE_DISPLAY, 0, 0);
        add_item(pida_pkg::MODE_DELETE, 1, 0);
        add_item(pida_pkg::MODE_DELETE, 0, 0);
        add_item(pida_pkg::MODE_DELETE, 0, 0);
        add_item(pida_pkg::MODE_DISPLAY, 0, 0);
        add_item(pida_pkg::MODE_DELETE, 0, -32'sh1);

        seq_no = 0;
        hold_next = 1'b1;
        while (planned_items < TOTAL_ITEMS) begin
            // long fill or drain runs only while they fit in the item budget
            room_for_long = (planned_items + DEPTH + 3 <= TOTAL_ITEMS);
            if (room_for_long && seq_no % 7 == 1) begin
                // fill to the top, hit the full case, show everything
                while (planned_count < DEPTH)
                    add_item(pida_pkg::MODE_INSERT, $urandom_range(0, planned_count),
                             pick_value());
                add_item(pida_pkg::MODE_INSERT, $urandom_range(0, 127), pick_value());
                add_item(pida_pkg::MODE_INSERT, $urandom_range(0, DEPTH), pick_value());
                add_item(pida_pkg::MODE_DISPLAY, $urandom_range(0, 127), $urandom);
                hold_next = 1'b1;
            end else if (room_for_long && seq_no % 7 == 4) begin
                floor_count = $urandom_range(0, 8);
                while (planned_count > floor_count)
                    add_item(pida_pkg::MODE_DELETE, $urandom_range(0, planned_count - 1),
                             $urandom);
                add_item(pida_pkg::MODE_DISPLAY, $urandom_range(0, 127), $urandom);
            end else begin
                repeat ($urandom_range(8, 16)) add_mixed_op();
            end
            seq_no++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_backlog.size() != 0 || in_valid) @(posedge i_clk);
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
